>>> hdl/spod_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spod_pkg: shared types and constants
// Store sizing, queue sizing and the record types passed between the
// front, the queue and the back of the sphere overlap detector.
// ----------------------------------------------------------------------------
package spod_pkg;

	localparam int MAX_PARTICLES = 8;
	localparam int IDX_W         = $clog2(MAX_PARTICLES);
	localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
	localparam int QDEPTH        = 2;
	localparam int QPTR_W        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_DETECT = 1'b1;

	localparam logic [14:0] NORM_ONE = 15'd16384;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [QPTR_W-1:0] qptr_t;
	typedef logic [QPTR_W:0]   qcnt_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [30:0] radius;
		logic [15:0] rest;
	} particle_t;

	// one overlapping pair, or an end-of-run token
	typedef struct packed {
		logic        is_end;
		logic        any;
		logic [2:0]  fi;
		logic [2:0]  si;
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] az;
		logic        neg_x;
		logic        neg_y;
		logic        neg_z;
		logic [65:0] m2;
		logic [31:0] rs;
		logic [15:0] rmin;
	} pair_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> hdl/sphere_pair_overlap_detect_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_pair_overlap_detect_top: brute-force sphere overlap detector
// Stores up to MAX_PARTICLES spheres and on detect emits one contact beat
// per overlapping pair i<j, or a single found=0 beat.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall): kind=0 loads one sphere into the
//    next free slot (dropped when full), kind=1 starts a detect run and
//    empties the store afterwards.
//  - A detect walks all pairs in the front, through READ, DIFF, SQR and
//    CMP per pair, and in_stall stays high until the walk and its end token are queued.
//  - Each overlapping pair then passes through the back: pop, square
//    root, three passes of the one shared divider for the normal, then
//    peek and output. The shared divider sets the rate.
//  - Output channel (out_valid/out_stall): one beat per contact, the last
//    one flagged by last; a run with no overlap gives one beat found=0,
//    last=1, all other fields zero.
//  - out_stall holds the result beat; the front keeps walking until the
//    two-entry pair queue fills, then waits.
//  - arst_n clears the store count, both state machines and the queue.
// ----------------------------------------------------------------------------
module sphere_pair_overlap_detect_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [30:0]        radius,
	input  logic [15:0]        particle_restitution,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic [2:0]         first_index,
	output logic [2:0]         second_index,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [31:0]        depth,
	output logic [15:0]        contact_restitution,
	output logic               last
);

	logic                q_push;
	logic                q_pop;
	spod_pkg::pair_t     q_wdata;
	spod_pkg::pair_t     q_head;
	spod_pkg::q_status_t q_st;

	// front: store and pair walk
	spod_front u_front (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.kind                 (kind),
		.pos_x                (pos_x),
		.pos_y                (pos_y),
		.pos_z                (pos_z),
		.radius               (radius),
		.particle_restitution (particle_restitution),
		.q_push               (q_push),
		.q_data               (q_wdata),
		.q_st                 (q_st)
	);

	// decouples the walk from the arithmetic
	spod_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wdata),
		.pop     (q_pop),
		.head    (q_head),
		.status  (q_st)
	);

	// back: sqrt, normalize, result beat
	spod_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.q_head              (q_head),
		.q_st                (q_st),
		.q_pop               (q_pop),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.found               (found),
		.first_index         (first_index),
		.second_index        (second_index),
		.normal_x            (normal_x),
		.normal_y            (normal_y),
		.normal_z            (normal_z),
		.depth               (depth),
		.contact_restitution (contact_restitution),
		.last                (last)
	);

endmodule

>>> hdl/spod_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spod_queue: pair queue
// Short FIFO between the pair walker and the contact builder.
// ----------------------------------------------------------------------------
module spod_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  spod_pkg::pair_t    wr_data,
	input  logic               pop,
	output spod_pkg::pair_t    head,
	output spod_pkg::q_status_t status
);

	spod_pkg::pair_t  mem [spod_pkg::QDEPTH];
	spod_pkg::qptr_t  wr_ptr_q;
	spod_pkg::qptr_t  rd_ptr_q;
	spod_pkg::qcnt_t  cnt_q;

	assign status.full  = (cnt_q == spod_pkg::qcnt_t'(spod_pkg::QDEPTH));
	assign status.empty = (cnt_q == '0);
	assign head         = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= spod_pkg::qptr_t'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= spod_pkg::qptr_t'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= spod_pkg::qcnt_t'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= spod_pkg::qcnt_t'(cnt_q - 1'b1);
			end
		end
	end

endmodule

>>> hdl/spod_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spod_front: particle store and pair walker
// Takes load and detect beats, walks pairs i<j, pushes overlaps and an
// end token into the pair queue.
// ----------------------------------------------------------------------------
module spod_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  logic [30:0]         radius,
	input  logic [15:0]         particle_restitution,
	output logic                q_push,
	output spod_pkg::pair_t     q_data,
	input  spod_pkg::q_status_t q_st
);

	typedef enum logic [5:0] {
		F_IDLE = 6'b000001,
		F_READ = 6'b000010,
		F_DIFF = 6'b000100,
		F_SQR  = 6'b001000,
		F_CMP  = 6'b010000,
		F_END  = 6'b100000
	} fstate_t;

	fstate_t              state_q;
	spod_pkg::cnt_t       count_q;
	spod_pkg::idx_t       i_q;
	spod_pkg::idx_t       j_q;
	logic                 any_q;
	spod_pkg::particle_t  store_mem [spod_pkg::MAX_PARTICLES];
	spod_pkg::particle_t  rd_i_q;
	spod_pkg::particle_t  rd_j_q;
	spod_pkg::particle_t  new_p;
	logic                 accept;
	logic                 load_we;
	logic [32:0]          dx_w, dy_w, dz_w;
	logic [31:0]          ax_q, ay_q, az_q;
	logic                 nx_q, ny_q, nz_q;
	logic [31:0]          rs_q;
	logic [15:0]          rmin_q;
	logic [63:0]          sqx_q, sqy_q, sqz_q, rs2_q;
	logic [65:0]          m2_w;
	logic                 ovl;
	logic                 last_j, last_i;

	function automatic logic [31:0] mag33(input logic [32:0] d);
		logic [32:0] n;
		n = -d;
		return d[32] ? n[31:0] : d[31:0];
	endfunction

	assign accept  = in_valid && !in_stall;
	assign in_stall = (state_q != F_IDLE);
	assign load_we = accept && (kind == spod_pkg::KIND_LOAD)
		&& (count_q < spod_pkg::cnt_t'(spod_pkg::MAX_PARTICLES));

	assign new_p.x      = pos_x;
	assign new_p.y      = pos_y;
	assign new_p.z      = pos_z;
	assign new_p.radius = radius;
	assign new_p.rest   = particle_restitution;

	always_ff @(posedge clk) begin
		if (load_we) begin
			store_mem[count_q[spod_pkg::IDX_W-1:0]] <= new_p;
		end
		rd_i_q <= store_mem[i_q];
		rd_j_q <= store_mem[j_q];
	end

	assign dx_w = {rd_i_q.x[31], rd_i_q.x} - {rd_j_q.x[31], rd_j_q.x};
	assign dy_w = {rd_i_q.y[31], rd_i_q.y} - {rd_j_q.y[31], rd_j_q.y};
	assign dz_w = {rd_i_q.z[31], rd_i_q.z} - {rd_j_q.z[31], rd_j_q.z};

	// difference and square stages, one pair at a time
	always_ff @(posedge clk) begin
		if (state_q == F_DIFF) begin
			ax_q   <= mag33(dx_w);
			ay_q   <= mag33(dy_w);
			az_q   <= mag33(dz_w);
			nx_q   <= dx_w[32];
			ny_q   <= dy_w[32];
			nz_q   <= dz_w[32];
			rs_q   <= {1'b0, rd_i_q.radius} + {1'b0, rd_j_q.radius};
			rmin_q <= (rd_i_q.rest < rd_j_q.rest) ? rd_i_q.rest : rd_j_q.rest;
		end
		if (state_q == F_SQR) begin
			sqx_q <= ax_q * ax_q;
			sqy_q <= ay_q * ay_q;
			sqz_q <= az_q * az_q;
			rs2_q <= rs_q * rs_q;
		end
	end

	assign m2_w = {2'b00, sqx_q} + {2'b00, sqy_q} + {2'b00, sqz_q};
	assign ovl  = (m2_w <= {2'b00, rs2_q});

	assign last_j = ((spod_pkg::cnt_t'(j_q) + spod_pkg::cnt_t'(1)) == count_q);
	assign last_i = ((spod_pkg::cnt_t'(i_q) + spod_pkg::cnt_t'(2)) == count_q);

	always_comb begin
		q_data.is_end = (state_q == F_END);
		q_data.any    = any_q;
		q_data.fi     = 3'(i_q);
		q_data.si     = 3'(j_q);
		q_data.ax     = ax_q;
		q_data.ay     = ay_q;
		q_data.az     = az_q;
		q_data.neg_x  = nx_q;
		q_data.neg_y  = ny_q;
		q_data.neg_z  = nz_q;
		q_data.m2     = m2_w;
		q_data.rs     = rs_q;
		q_data.rmin   = rmin_q;
	end

	assign q_push = !q_st.full
		&& (((state_q == F_CMP) && ovl) || (state_q == F_END));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			count_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			any_q   <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (load_we) begin
						count_q <= spod_pkg::cnt_t'(count_q + 1'b1);
					end
					if (accept && (kind == spod_pkg::KIND_DETECT)) begin
						any_q <= 1'b0;
						i_q   <= '0;
						j_q   <= spod_pkg::idx_t'(1);
						if (count_q < spod_pkg::cnt_t'(2)) begin
							state_q <= F_END;
						end else begin
							state_q <= F_READ;
						end
					end
				end
				F_READ: state_q <= F_DIFF;
				F_DIFF: state_q <= F_SQR;
				F_SQR:  state_q <= F_CMP;
				F_CMP: begin
					if (!ovl || !q_st.full) begin
						any_q <= any_q | ovl;
						if (last_j) begin
							if (last_i) begin
								state_q <= F_END;
							end else begin
								i_q     <= spod_pkg::idx_t'(i_q + 1'b1);
								j_q     <= spod_pkg::idx_t'(i_q + 2'd2);
								state_q <= F_READ;
							end
						end else begin
							j_q     <= spod_pkg::idx_t'(j_q + 1'b1);
							state_q <= F_READ;
						end
					end
				end
				F_END: begin
					if (!q_st.full) begin
						count_q <= '0;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_st.full)
		else $error("pair pushed into a full queue");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spod_pkg::cnt_t'(spod_pkg::MAX_PARTICLES))
		else $error("particle count beyond store size");
`endif

endmodule

>>> hdl/spod_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spod_back: contact builder
// Pops pairs, runs a restoring square root and a shared restoring divider
// for the three normal components, and holds the result beat.
// ----------------------------------------------------------------------------
module spod_back (
	input  logic                clk,
	input  logic                arst_n,
	input  spod_pkg::pair_t     q_head,
	input  spod_pkg::q_status_t q_st,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                found,
	output logic [2:0]          first_index,
	output logic [2:0]          second_index,
	output logic signed [15:0]  normal_x,
	output logic signed [15:0]  normal_y,
	output logic signed [15:0]  normal_z,
	output logic [31:0]         depth,
	output logic [15:0]         contact_restitution,
	output logic                last
);

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_SQRT = 5'b00010,
		B_DIV  = 5'b00100,
		B_PEEK = 5'b01000,
		B_OUT  = 5'b10000
	} bstate_t;

	bstate_t      state_q;
	logic [31:0]  ax_q, ay_q, az_q;
	logic         nx_q, ny_q, nz_q;
	logic [65:0]  v_q;
	logic [31:0]  rs_q;
	logic [35:0]  rem_q;
	logic [32:0]  root_q;
	logic [5:0]   scnt_q;
	logic [35:0]  rem_sh, trial;
	logic         s_ge;
	logic [32:0]  root_nx;
	logic [46:0]  drem_q, dv_q, num_w;
	logic [14:0]  dq_q, dq_nx, qcl;
	logic [3:0]   dstep_q;
	logic [1:0]   comp_q;
	logic         d_ge, neg_w;
	logic [31:0]  a_w;
	logic [15:0]  mag16, sval;

	logic         found_q, last_q;
	logic [2:0]   fi_q, si_q;
	logic [15:0]  nxo_q, nyo_q, nzo_q;
	logic [31:0]  depth_q;
	logic [15:0]  rest_q;

	// square root, two radicand bits per cycle
	assign rem_sh  = {rem_q[33:0], v_q[65:64]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign s_ge    = (rem_sh >= trial);
	assign root_nx = {root_q[31:0], s_ge};

	always_comb begin
		case (comp_q)
			2'd0:    begin a_w = ax_q; neg_w = nx_q; end
			2'd1:    begin a_w = ay_q; neg_w = ny_q; end
			2'd2:    begin a_w = az_q; neg_w = nz_q; end
			default: begin a_w = '0;   neg_w = 1'b0; end
		endcase
	end

	// rounded quotient: (a * 2^14 + dist/2) / dist
	assign num_w = {1'b0, a_w, 14'b0} + {15'b0, root_q[32:1]};
	assign d_ge  = (drem_q >= dv_q);
	assign dq_nx = {dq_q[13:0], d_ge};
	assign qcl   = (root_q == '0) ? 15'd0
		: ((dq_nx > spod_pkg::NORM_ONE) ? spod_pkg::NORM_ONE : dq_nx);
	assign mag16 = {1'b0, qcl};
	assign sval  = neg_w ? 16'(-mag16) : mag16;

	assign q_pop = !q_st.empty
		&& ((state_q == B_IDLE) || ((state_q == B_PEEK) && q_head.is_end));

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!q_st.empty) begin
					ax_q    <= q_head.ax;
					ay_q    <= q_head.ay;
					az_q    <= q_head.az;
					nx_q    <= q_head.neg_x;
					ny_q    <= q_head.neg_y;
					nz_q    <= q_head.neg_z;
					v_q     <= q_head.m2;
					rs_q    <= q_head.rs;
					rem_q   <= '0;
					root_q  <= '0;
					fi_q    <= q_head.is_end ? 3'd0 : q_head.fi;
					si_q    <= q_head.is_end ? 3'd0 : q_head.si;
					rest_q  <= q_head.is_end ? 16'd0 : q_head.rmin;
					found_q <= !q_head.is_end;
					if (q_head.is_end) begin
						nxo_q   <= '0;
						nyo_q   <= '0;
						nzo_q   <= '0;
						depth_q <= '0;
						last_q  <= 1'b1;
					end
				end
			end
			B_SQRT: begin
				rem_q  <= s_ge ? (rem_sh - trial) : rem_sh;
				root_q <= root_nx;
				v_q    <= {v_q[63:0], 2'b00};
				if (scnt_q == 6'd32) begin
					depth_q <= rs_q - root_nx[31:0];
				end
			end
			B_DIV: begin
				if (dstep_q == 4'd0) begin
					drem_q <= num_w;
					dv_q   <= {root_q, 14'b0};
					dq_q   <= '0;
				end else begin
					drem_q <= d_ge ? (drem_q - dv_q) : drem_q;
					dv_q   <= dv_q >> 1;
					dq_q   <= dq_nx;
					if (dstep_q == 4'd15) begin
						case (comp_q)
							2'd0:    nxo_q <= sval;
							2'd1:    nyo_q <= sval;
							default: nzo_q <= sval;
						endcase
					end
				end
			end
			B_PEEK: begin
				last_q <= q_head.is_end;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			scnt_q  <= '0;
			dstep_q <= '0;
			comp_q  <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (!q_st.empty) begin
						scnt_q  <= '0;
						state_q <= q_head.is_end ? B_OUT : B_SQRT;
					end
				end
				B_SQRT: begin
					scnt_q <= scnt_q + 1'b1;
					if (scnt_q == 6'd32) begin
						dstep_q <= '0;
						comp_q  <= '0;
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					if (dstep_q == 4'd15) begin
						dstep_q <= '0;
						comp_q  <= comp_q + 1'b1;
						if (comp_q == 2'd2) begin
							state_q <= B_PEEK;
						end
					end else begin
						dstep_q <= dstep_q + 1'b1;
					end
				end
				B_PEEK: begin
					if (!q_st.empty) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (!out_stall) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_valid           = (state_q == B_OUT);
	assign found               = found_q;
	assign first_index         = fi_q;
	assign second_index        = si_q;
	assign normal_x            = nxo_q;
	assign normal_y            = nyo_q;
	assign normal_z            = nzo_q;
	assign depth               = depth_q;
	assign contact_restitution = rest_q;
	assign last                = last_q;

`ifndef SYNTH
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> last)
		else $error("no-contact beat without last");
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (normal_x <= 16'sd16384) && (normal_x >= -16'sd16384)
			&& (normal_y <= 16'sd16384) && (normal_y >= -16'sd16384)
			&& (normal_z <= 16'sd16384) && (normal_z >= -16'sd16384))
		else $error("normal component out of range");
`endif

endmodule
